@@ hw/rtl/crx_pkg.sv @@
// Shared types and constants for the checksummed packet receiver.
// Holds the frame byte codes, the parser phase type and the result/status structs.
// Depends on nothing; the top level, the parser and the result register refer to it by scoped names.
package crx_pkg;

  // Longest payload that the parser accepts, and the widths that follow from it.
  localparam int PAYLOAD_MAX = 32;
  localparam int LEN_W       = $clog2(PAYLOAD_MAX + 1);
  localparam int KEEP_BYTES  = 6;
  localparam int KEEP_IDX_W  = $clog2(KEEP_BYTES);

  // Port widths of the result channel.
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 2;

  // Frame byte codes.
  localparam logic [7:0] HDR1_A      = 8'hB5;
  localparam logic [7:0] HDR1_B      = 8'hC5;
  localparam logic [7:0] HDR2_VEL    = 8'h5B;
  localparam logic [7:0] HDR2_MOTOR  = 8'h5C;
  localparam logic [7:0] CMD_VEL     = 8'h01;
  localparam logic [7:0] CMD_MOTOR   = 8'h02;
  localparam logic [7:0] SUM_MODULUS = 8'hFF;
  localparam logic [7:0] TRAIL_A     = 8'hBB;
  localparam logic [7:0] TRAIL_B     = 8'hCC;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HEAD1,
    PH_HEAD2,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CHECK,
    PH_TRAIL
  } phase_t;

  // One decoded packet result.
  typedef struct packed {
    logic               packet_type;
    logic               checksum_ok;
    logic signed [15:0] velocity_x;
    logic signed [15:0] velocity_y;
    logic signed [15:0] velocity_w;
    logic [7:0]         motor_value;
  } result_t;

  // Parser status seen by the top level.
  typedef struct packed {
    phase_t           phase;
    logic             emit;
    logic [LEN_W-1:0] bytes_seen;
    logic [LEN_W-1:0] expected_length;
  } status_t;

endpackage

@@ hw/rtl/checksummed_packet_receiver.sv @@
// Top level of the checksummed packet receiver: input register, parser, result register.
// Depends on crx_pkg, crx_in_stage, crx_parser and crx_out_stage.
//
//   Port group | Direction | Payload
//   in_*       | slave     | tdata[7:0] rx_byte
//   out_*      | master    | tdata[55:0] velocities and motor byte, tuser[1:0] type and check
//
// One byte is taken per cycle while in_tready is high. A byte is parsed while it sits in the
// input register, and the result of a check byte is loaded into the result register when that byte moves on.
// in_tready falls only while a check byte waits in the input register and the result
// register still holds a beat that is not taken. Reset is synchronous, active low,
// and returns the parser to hunting for a first header byte.
module checksummed_packet_receiver (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] velocity_x, [31:16] velocity_y, [47:32] velocity_w, [55:48] motor_value
  output logic [crx_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] packet_type, [1] checksum_ok
  output logic [crx_pkg::OUT_USER_W-1:0] out_tuser
);

  logic             byte_vld;
  logic [7:0]       byte_val;
  logic             advance;
  logic             out_load;
  crx_pkg::status_t status;
  crx_pkg::result_t result;

  // A byte moves on unless it makes a result that has nowhere to go.
  assign advance  = byte_vld && (!status.emit || !out_tvalid || out_tready);
  assign out_load = advance && status.emit;

  crx_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .byte_vld  (byte_vld),
    .byte_val  (byte_val)
  );

  crx_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (byte_val),
    .status  (status),
    .result  (result)
  );

  crx_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .result     (result),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // A parsed check byte leaves the parser waiting for the trailer with a result shown.
  a_check_to_trail: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (status.phase == crx_pkg::PH_TRAIL) && out_tvalid)
    else $error("check byte did not produce a result and trailer wait");

  // The payload count never reaches the length while payload bytes are due.
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (status.phase == crx_pkg::PH_DATA) |-> (status.bytes_seen < status.expected_length))
    else $error("payload count out of range");

  // A byte that is held back stays in the input register unchanged.
  a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_vld && !advance) |=> (byte_vld && $stable(byte_val)))
    else $error("held byte was lost or changed");

endmodule

@@ hw/rtl/crx_in_stage.sv @@
// Input register of the packet receiver: holds one received byte until parsed.
// Does not use crx_pkg; plain byte payload.
module crx_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       advance,
  output logic       byte_vld,
  output logic [7:0] byte_val
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  // The register can take a beat when it is empty or its byte moves on now.
  assign in_tready = !vld_r || advance;
  assign vld_nxt   = in_tready ? in_tvalid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload register, loaded on every accepted beat.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  assign byte_vld = vld_r;
  assign byte_val = byte_r;

endmodule

@@ hw/rtl/crx_parser.sv @@
// Frame parser: phase machine, running checksum, length count and payload capture.
// Depends on crx_pkg for phase codes, byte codes and the result/status structs.
module crx_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output crx_pkg::status_t status,
  output crx_pkg::result_t result
);

  crx_pkg::phase_t phase_r;
  crx_pkg::phase_t phase_nxt;

  logic                      kind_r;
  logic                      kind_nxt;
  logic [crx_pkg::LEN_W-1:0] exp_r;
  logic [crx_pkg::LEN_W-1:0] exp_nxt;
  logic [crx_pkg::LEN_W-1:0] seen_r;
  logic [crx_pkg::LEN_W-1:0] seen_nxt;
  logic [7:0]                sum_r;
  logic [7:0]                sum_nxt;
  logic [7:0]                payload_r   [crx_pkg::KEEP_BYTES];
  logic [7:0]                payload_nxt [crx_pkg::KEEP_BYTES];

  logic                      is_hdr1;
  logic                      is_hdr2;
  logic                      is_cmd;
  logic                      is_trail;
  logic                      too_long;
  logic                      len_zero;
  logic [crx_pkg::LEN_W:0]   seen_inc;
  logic                      data_done;
  logic [7:0]                sum_add;
  logic [7:0]                sum_mod;

  // Byte classification against the frame codes.
  assign is_hdr1  = (rx_byte == crx_pkg::HDR1_A) || (rx_byte == crx_pkg::HDR1_B);
  assign is_hdr2  = (rx_byte == crx_pkg::HDR2_VEL) || (rx_byte == crx_pkg::HDR2_MOTOR);
  assign is_cmd   = (rx_byte == (kind_r ? crx_pkg::CMD_MOTOR : crx_pkg::CMD_VEL));
  assign is_trail = (rx_byte == crx_pkg::TRAIL_A) || (rx_byte == crx_pkg::TRAIL_B);
  assign too_long = {1'b0, rx_byte} > 9'(crx_pkg::PAYLOAD_MAX);
  assign len_zero = (rx_byte == 8'h00);

  assign seen_inc  = {1'b0, seen_r} + 1'b1;
  assign data_done = seen_inc >= {1'b0, exp_r};
  assign sum_add   = sum_r + rx_byte;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      unique case (phase_r)
        crx_pkg::PH_HEAD1: begin
          if (is_hdr1) phase_nxt = crx_pkg::PH_HEAD2;
        end
        crx_pkg::PH_HEAD2: begin
          phase_nxt = is_hdr2 ? crx_pkg::PH_CMD : crx_pkg::PH_HEAD1;
        end
        crx_pkg::PH_CMD: begin
          phase_nxt = is_cmd ? crx_pkg::PH_LEN : crx_pkg::PH_HEAD1;
        end
        crx_pkg::PH_LEN: begin
          if (too_long) begin
            phase_nxt = crx_pkg::PH_HEAD1;
          end else if (len_zero) begin
            phase_nxt = crx_pkg::PH_CHECK;
          end else begin
            phase_nxt = crx_pkg::PH_DATA;
          end
        end
        crx_pkg::PH_DATA: begin
          if (data_done) phase_nxt = crx_pkg::PH_CHECK;
        end
        crx_pkg::PH_CHECK: begin
          phase_nxt = crx_pkg::PH_TRAIL;
        end
        crx_pkg::PH_TRAIL: begin
          if (is_trail) phase_nxt = crx_pkg::PH_HEAD1;
        end
        default: begin
          phase_nxt = crx_pkg::PH_HEAD1;
        end
      endcase
    end
  end

  // Datapath updates: checksum, kind, length, count and captured payload.
  always_comb begin
    kind_nxt = kind_r;
    exp_nxt  = exp_r;
    seen_nxt = seen_r;
    sum_nxt  = sum_r;
    for (int i = 0; i < crx_pkg::KEEP_BYTES; i++) begin
      payload_nxt[i] = payload_r[i];
    end
    if (step) begin
      unique case (phase_r)
        crx_pkg::PH_HEAD1: begin
          if (is_hdr1) begin
            sum_nxt = sum_add;
          end else begin
            sum_nxt  = 8'h00;
            seen_nxt = '0;
          end
        end
        crx_pkg::PH_HEAD2: begin
          if (is_hdr2) begin
            kind_nxt = (rx_byte == crx_pkg::HDR2_MOTOR);
            sum_nxt  = sum_add;
          end else begin
            sum_nxt  = 8'h00;
            seen_nxt = '0;
          end
        end
        crx_pkg::PH_CMD: begin
          if (is_cmd) begin
            sum_nxt = sum_add;
          end else begin
            sum_nxt  = 8'h00;
            seen_nxt = '0;
          end
        end
        crx_pkg::PH_LEN: begin
          if (too_long) begin
            sum_nxt  = 8'h00;
            seen_nxt = '0;
          end else begin
            exp_nxt  = rx_byte[crx_pkg::LEN_W-1:0];
            sum_nxt  = sum_add;
            seen_nxt = '0;
          end
        end
        crx_pkg::PH_DATA: begin
          // Only the leading payload bytes are kept.
          if (seen_r < crx_pkg::LEN_W'(crx_pkg::KEEP_BYTES)) begin
            payload_nxt[seen_r[crx_pkg::KEEP_IDX_W-1:0]] = rx_byte;
          end
          sum_nxt  = sum_add;
          seen_nxt = seen_inc[crx_pkg::LEN_W-1:0];
        end
        crx_pkg::PH_CHECK: begin
          sum_nxt  = 8'h00;
          seen_nxt = '0;
        end
        crx_pkg::PH_TRAIL: begin
          if (is_trail) begin
            sum_nxt  = 8'h00;
            seen_nxt = '0;
          end
        end
        default: begin
          sum_nxt  = 8'h00;
          seen_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= crx_pkg::PH_HEAD1;
      kind_r  <= 1'b0;
      exp_r   <= '0;
      seen_r  <= '0;
      sum_r   <= 8'h00;
      for (int i = 0; i < crx_pkg::KEEP_BYTES; i++) begin
        payload_r[i] <= 8'h00;
      end
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      exp_r   <= exp_nxt;
      seen_r  <= seen_nxt;
      sum_r   <= sum_nxt;
      for (int i = 0; i < crx_pkg::KEEP_BYTES; i++) begin
        payload_r[i] <= payload_nxt[i];
      end
    end
  end

  // The 8-bit sum reduced modulo 255: only the all-ones value folds to zero.
  assign sum_mod = (sum_r == crx_pkg::SUM_MODULUS) ? 8'h00 : sum_r;

  // Result of the check byte currently presented.
  always_comb begin
    result.packet_type = kind_r;
    result.checksum_ok = (rx_byte == sum_mod);
    result.velocity_x  = {payload_r[0], payload_r[1]};
    result.velocity_y  = {payload_r[2], payload_r[3]};
    result.velocity_w  = {payload_r[4], payload_r[5]};
    result.motor_value = payload_r[0];
  end

  always_comb begin
    status.phase           = phase_r;
    status.emit            = (phase_r == crx_pkg::PH_CHECK);
    status.bytes_seen      = seen_r;
    status.expected_length = exp_r;
  end

endmodule

@@ hw/rtl/crx_out_stage.sv @@
// Result register of the packet receiver, driving the master-side stream.
// Depends on crx_pkg for the result struct and port widths.
module crx_out_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  crx_pkg::result_t               result,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] velocity_x, [31:16] velocity_y, [47:32] velocity_w, [55:48] motor_value
  output logic [crx_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] packet_type, [1] checksum_ok
  output logic [crx_pkg::OUT_USER_W-1:0] out_tuser
);

  logic             vld_r;
  logic             vld_nxt;
  crx_pkg::result_t res_r;

  // A new result replaces a taken one; otherwise a taken beat clears and one not taken holds.
  assign vld_nxt = load ? 1'b1 : (out_tready ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {res_r.motor_value, res_r.velocity_w, res_r.velocity_y,
                       res_r.velocity_x};
  assign out_tuser  = {res_r.checksum_ok, res_r.packet_type};

endmodule
